// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the best-fit bin packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define BFBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define BFBP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bfbp_pkg.sv =====
// Shared constants and types of the best-fit bin packer.
package bfbp_pkg;

    localparam int MAX_BINS   = 64;
    localparam int IDX_W      = $clog2(MAX_BINS);
    localparam int CNT_W      = $clog2(MAX_BINS + 1);
    localparam int SIZE_W     = 16;
    localparam int FILL_W     = 17;
    localparam int COPIES_W   = 7;
    localparam int MAX_COPIES = 64;
    localparam int OUT_IDX_W  = 6;
    localparam int OUT_CNT_W  = 7;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    // Search token that walks the row of bin cells
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [FILL_W-1:0] fill;
        logic [IDX_W-1:0]  idx;
    } token_t;

    // Values every cell sees at once
    typedef struct packed {
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  open_count;
    } bcast_t;

    // Fill-level write into one cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [FILL_W-1:0] data;
    } fill_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/core/best_fit_bin_packer.sv =====
// Online best-fit bin packer: top level with the sequencer and the row of bin cells.
//
// Input channel s_*: one transfer per item; tdata carries the item size and copy count,
// tuser the clear flag. The item is taken only while the block is idle.
// Output channel m_*: one transfer per copy (at most 64), tlast marks the final copy's result.
// Configuration: cfg_wr_en writes the bin capacity from cfg_wr_data; write it while idle.
// Timing: every copy launches a search token that walks the 64 bin cells, one cell per
// cycle; a copy goes through launch, the walk of the 64 cells and placement in turn,
// and the copies of an item run one after another until the last one is placed.
// A result waits in an output register; the next copy's search runs meanwhile, and
// placement stalls only while that register is full and m_tready is low.
// An item with zero copies gives no result, but its clear flag still empties the bins.
// Reset leaves no bins open, capacity 65535 and no result pending; the cell fill levels
// need no clearing since only open bins are ever read.
module best_fit_bin_packer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bfbp_pkg::S_DATA_W-1:0] s_tdata,   // item_size[15:0], copies[22:16], zero
    input  logic [0:0]                    s_tuser,   // clear_bins[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfbp_pkg::M_DATA_W-1:0] m_tdata,   // bin_index[5:0], bins_used[12:6],
                                                     // opened_new[13], oversize[14],
                                                     // overflow[15]
    output logic                          m_tlast,   // last_copy
    input  logic                          cfg_wr_en,
    input  logic [bfbp_pkg::SIZE_W-1:0]   cfg_wr_data
);
    import bfbp_pkg::*;

    token_t   tok [0:MAX_BINS];
    bcast_t   bcast;
    fill_wr_t fill_wr;

    bfbp_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tok_head    (tok[0]),
        .tok_tail    (tok[MAX_BINS]),
        .bcast       (bcast),
        .fill_wr     (fill_wr)
    );

    // Chain the bin cells; the token moves one cell per cycle
    genvar gi;
    generate
        for (gi = 0; gi < MAX_BINS; gi++)
        begin : g_cell
            bfbp_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(gi)),
                .bcast    (bcast),
                .fill_wr  (fill_wr),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

endmodule

// ===== rtl/core/bfbp_cell.sv =====
// One bin of the packer: holds its fill level and updates the passing search token.
module bfbp_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [bfbp_pkg::IDX_W-1:0] cell_idx,
    input  bfbp_pkg::bcast_t         bcast,
    input  bfbp_pkg::fill_wr_t       fill_wr,
    input  bfbp_pkg::token_t         tok_in,
    output bfbp_pkg::token_t         tok_out
);
    import bfbp_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              is_open;
    logic              fits;
    logic              take;

    // Check room: fill + size must not pass the capacity
    always_comb
    begin
        is_open = {1'b0, cell_idx} < bcast.open_count;
        fits    = ({1'b0, fill_reg} + {2'b0, bcast.size}) <= {2'b0, bcast.cap};
        take    = tok_in.valid && is_open && fits
                  && (!tok_in.found || (fill_reg > tok_in.fill));
    end

    // Claim the token when this bin is the fullest fit so far
    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.fill  = fill_reg;
            tok_next.idx   = cell_idx;
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Store a new fill level when addressed
    always_ff @(posedge clk)
    begin
        if (fill_wr.en && (fill_wr.idx == cell_idx))
        begin
            fill_reg <= fill_wr.data;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/bfbp_ctrl.sv =====
// Sequencer of the packer: takes items, launches searches, places copies, drives results.
`include "assert_macros.svh"

module bfbp_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bfbp_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfbp_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [bfbp_pkg::SIZE_W-1:0]   cfg_wr_data,
    output bfbp_pkg::token_t              tok_head,
    input  bfbp_pkg::token_t              tok_tail,
    output bfbp_pkg::bcast_t              bcast,
    output bfbp_pkg::fill_wr_t            fill_wr
);
    import bfbp_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   cap_reg, cap_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [COPIES_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0]    open_count_reg, open_count_next;
    logic                found_reg, found_next;
    logic [FILL_W-1:0]   best_fill_reg, best_fill_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic                s_xfer;
    logic [SIZE_W-1:0]   in_size;
    logic [COPIES_W-1:0] in_copies;
    logic [COPIES_W-1:0] in_count;
    logic                can_load;
    logic                place;
    logic [IDX_W-1:0]    dec_idx;
    logic [FILL_W-1:0]   dec_fill;
    logic                dec_wen;
    logic                dec_opened;
    logic                dec_over;
    logic [CNT_W-1:0]    dec_count;

    // Unpack the input transfer
    always_comb
    begin
        in_size   = s_tdata[SIZE_W-1:0];
        in_copies = s_tdata[SIZE_W+COPIES_W-1:SIZE_W];
        in_count  = (in_copies > COPIES_W'(MAX_COPIES)) ? COPIES_W'(MAX_COPIES) : in_copies;
        s_xfer    = s_tvalid && s_tready;
        can_load  = !out_valid_reg || m_tready;
        place     = (state_reg == ST_WRITE) && can_load;
    end

    // Decide where the current copy goes
    always_comb
    begin
        dec_idx    = '0;
        dec_fill   = '0;
        dec_wen    = 1'b0;
        dec_opened = 1'b0;
        dec_over   = 1'b0;
        dec_count  = open_count_reg;
        if (found_reg)
        begin
            dec_idx  = best_idx_reg;
            dec_fill = FILL_W'(best_fill_reg + FILL_W'(size_reg));
            dec_wen  = 1'b1;
        end
        else if (open_count_reg < CNT_W'(MAX_BINS))
        begin
            dec_idx    = IDX_W'(open_count_reg);
            dec_fill   = FILL_W'(size_reg);
            dec_wen    = 1'b1;
            dec_opened = 1'b1;
            dec_count  = CNT_W'(open_count_reg + 1'b1);
        end
        else
        begin
            dec_over = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer && (in_count != '0))
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_tail.valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    state_next = (remain_reg == COPIES_W'(1)) ? ST_IDLE : ST_LAUNCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        size_next       = size_reg;
        remain_next     = remain_reg;
        open_count_next = open_count_reg;
        found_next      = found_reg;
        best_fill_next  = best_fill_reg;
        best_idx_next   = best_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        tok_head        = '0;
        tok_head.valid  = (state_reg == ST_LAUNCH);

        fill_wr.en      = place && dec_wen;
        fill_wr.idx     = dec_idx;
        fill_wr.data    = dec_fill;

        // Take a new item; a clear empties the bins first
        if (s_xfer)
        begin
            size_next   = in_size;
            remain_next = in_count;
            if (s_tuser[0])
            begin
                open_count_next = '0;
            end
        end

        // Capture the search result at the end of the row
        if ((state_reg == ST_SCAN) && tok_tail.valid)
        begin
            found_next     = tok_tail.found;
            best_fill_next = tok_tail.fill;
            best_idx_next  = tok_tail.idx;
        end

        // Place the copy and load the result register
        if (place)
        begin
            open_count_next = dec_count;
            remain_next     = COPIES_W'(remain_reg - 1'b1);
            out_valid_next  = 1'b1;
            out_data_next   = {dec_over, (size_reg > cap_reg), dec_opened,
                               OUT_CNT_W'(dec_count), OUT_IDX_W'(dec_idx)};
            out_last_next   = (remain_reg == COPIES_W'(1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= '1;
            open_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            open_count_reg <= open_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        remain_reg    <= remain_next;
        found_reg     <= found_next;
        best_fill_reg <= best_fill_next;
        best_idx_reg  <= best_idx_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign bcast.cap        = cap_reg;
    assign bcast.size       = size_reg;
    assign bcast.open_count = open_count_reg;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign m_tlast          = out_last_reg;

    `BFBP_ASSERT(a_tail_only_in_scan, clk, rst_n, !tok_tail.valid || (state_reg == ST_SCAN), "search token left the row outside a scan")
    `BFBP_ASSERT(a_count_bounded, clk, rst_n, open_count_reg <= CNT_W'(MAX_BINS), "open bin count above the bin total")
    `BFBP_ASSERT_NEXT(a_open_bumps_count, clk, rst_n, place && dec_opened, open_count_reg == CNT_W'($past(open_count_reg) + 1'b1), "opening a bin did not raise the count")
    `BFBP_ASSERT_NEXT(a_result_not_lost, clk, rst_n, out_valid_reg && !m_tready, out_valid_reg && $stable(out_data_reg), "stalled result changed or vanished")

endmodule
